[rtl/pts_pkg.sv]
// Shared opcode, task state and status codes for the priority task scheduler.
package pts_pkg;

  localparam int TICK_W   = 32;
  localparam int IDX_W    = 3;
  localparam int PRIO_W   = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_ADD      = 3'd1,
    OP_DISPATCH = 3'd2,
    OP_SLEEP    = 3'd3,
    OP_DONE     = 3'd4,
    OP_SUSPEND  = 3'd5,
    OP_RESUME   = 3'd6
  } opcode_t;

  typedef enum logic [1:0] {
    ST_READY     = 2'd0,
    ST_RUNNING   = 2'd1,
    ST_SLEEPING  = 2'd2,
    ST_SUSPENDED = 2'd3
  } task_state_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NONE    = 2'd2,
    STAT_IGNORED = 2'd3
  } status_t;

endpackage

[rtl/pts_mem.sv]
// Task table memory with one write port and one registered read port.
module pts_mem #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 70,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/priority_task_scheduler.sv]
// Top level of the priority task scheduler: command sequencer around the task table memory.
//
// Each input transaction is one scheduler command and yields exactly one result transaction.
// All per-task state lives in one memory read and written back slot by slot. ADD writes a new
// slot on accept when the table has room and, like every ignored command, then goes straight
// to the response; SLEEP, DONE, SUSPEND and RESUME read, modify and write back one slot. TICK
// and DISPATCH sweep every added slot through the memory's single read port, one slot per
// cycle, and a DISPATCH that finds a ready task adds a final write of the chosen slot. The
// result becomes valid in the cycle in which the block is ready for the next command. A
// finished result is held in the output register and the next command is accepted while it
// waits; a command whose own result is ready stalls in its last cycle until the receiver
// takes the previous one.
module priority_task_scheduler
  import pts_pkg::*;
#(
  parameter int TASK_SLOTS    = 8,
  parameter int PRIORITY_BITS = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_opcode,
  input  logic [IDX_W-1:0]    in_task_index,
  input  logic [PRIO_W-1:0]   in_priority_req,
  input  logic [TICK_W-1:0]   in_sleep_ticks,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [IDX_W-1:0]    out_chosen_index,
  output logic [TICK_W-1:0]   out_run_time
);

  localparam int SW = $clog2(TASK_SLOTS);
  localparam int TW = $clog2(TASK_SLOTS + 1);

  typedef struct packed {
    logic [TICK_W-1:0]        last_run;
    logic [TICK_W-1:0]        sleep_cnt;
    logic [PRIORITY_BITS-1:0] prio;
    task_state_t              st;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RMW_WR,
    S_PICK,
    S_RESP
  } fsm_t;

  fsm_t                     state_r;
  opcode_t                  op_r;
  logic [TICK_W-1:0]        ticks_r;
  logic [TW-1:0]            tiu_r;
  logic [TICK_W-1:0]        tick_r;
  logic                     run_valid_r;
  logic [SW-1:0]            run_idx_r;
  logic [TW-1:0]            rd_ptr_r;
  logic                     pend_r;
  logic [SW-1:0]            pend_addr_r;
  logic                     fin_en_r;
  logic [SW-1:0]            fin_idx_r;
  logic [SW-1:0]            rmw_addr_r;
  logic                     best_found_r;
  logic [PRIORITY_BITS-1:0] best_prio_r;
  logic [SW-1:0]            best_idx_r;
  rec_t                     best_rec_r;
  status_t                  res_status_r;
  logic [IDX_W-1:0]         res_chosen_r;
  logic [TICK_W-1:0]        res_time_r;
  logic                     out_valid_r;
  status_t                  out_status_r;
  logic [IDX_W-1:0]         out_chosen_r;
  logic [TICK_W-1:0]        out_time_r;

  logic                     accept;
  opcode_t                  in_op;
  logic [PRIORITY_BITS-1:0] prio_in;
  logic                     idx_ok;
  logic                     scan_issue;
  logic                     scan_better;
  rec_t                     rd_data;
  rec_t                     scan_rec;
  rec_t                     rmw_rec;
  rec_t                     add_rec;
  rec_t                     pick_rec;
  logic                     mem_we;
  logic [SW-1:0]            mem_waddr;
  rec_t                     mem_wdata;
  logic                     mem_re;
  logic [SW-1:0]            mem_raddr;

  pts_mem #(
    .DEPTH(TASK_SLOTS),
    .WIDTH(REC_W),
    .AW   (SW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(rd_data)
  );

  assign in_ready         = (state_r == S_IDLE);
  assign accept           = in_valid && in_ready;
  assign in_op            = opcode_t'(in_opcode);
  assign prio_in          = PRIORITY_BITS'(in_priority_req);
  assign idx_ok           = 32'(in_task_index) < 32'(tiu_r);
  assign scan_issue       = (state_r == S_SCAN) && (rd_ptr_r < tiu_r);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_chosen_index = out_chosen_r;
  assign out_run_time     = out_time_r;

  always_comb begin
    scan_rec = rd_data;
    if (op_r == OP_TICK) begin
      if (scan_rec.st == ST_SLEEPING) begin
        if (scan_rec.sleep_cnt != '0) begin
          scan_rec.sleep_cnt = scan_rec.sleep_cnt - TICK_W'(1);
        end
        if (scan_rec.sleep_cnt == '0) begin
          scan_rec.st = ST_READY;
        end
      end
    end else if (fin_en_r && pend_addr_r == fin_idx_r && scan_rec.st == ST_RUNNING) begin
      scan_rec.st = ST_READY;
    end
    scan_better = (scan_rec.st == ST_READY) && (scan_rec.prio > best_prio_r);

    rmw_rec = rd_data;
    case (op_r)
      OP_SLEEP: begin
        rmw_rec.st        = ST_SLEEPING;
        rmw_rec.sleep_cnt = ticks_r;
      end
      OP_DONE: begin
        if (rmw_rec.st == ST_RUNNING) begin
          rmw_rec.st = ST_READY;
        end
      end
      OP_SUSPEND: rmw_rec.st = ST_SUSPENDED;
      OP_RESUME:  rmw_rec.st = ST_READY;
      default:    rmw_rec = rd_data;
    endcase

    add_rec      = '0;
    add_rec.prio = prio_in;
    add_rec.st   = ST_READY;

    pick_rec          = best_rec_r;
    pick_rec.st       = ST_RUNNING;
    pick_rec.last_run = tick_r;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_ADD: begin
              mem_we    = (tiu_r != TW'(TASK_SLOTS));
              mem_waddr = tiu_r[SW-1:0];
              mem_wdata = add_rec;
            end
            OP_SLEEP, OP_DONE: begin
              mem_re    = run_valid_r;
              mem_raddr = run_idx_r;
            end
            OP_SUSPEND, OP_RESUME: begin
              mem_re    = idx_ok;
              mem_raddr = SW'(in_task_index);
            end
            default: mem_re = 1'b0;
          endcase
        end
      end
      S_SCAN: begin
        mem_re    = scan_issue;
        mem_raddr = rd_ptr_r[SW-1:0];
        mem_we    = pend_r;
        mem_waddr = pend_addr_r;
        mem_wdata = scan_rec;
      end
      S_RMW_WR: begin
        mem_we    = 1'b1;
        mem_waddr = rmw_addr_r;
        mem_wdata = rmw_rec;
      end
      S_PICK: begin
        mem_we    = 1'b1;
        mem_waddr = best_idx_r;
        mem_wdata = pick_rec;
      end
      S_RESP: mem_we = 1'b0;
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tiu_r       <= '0;
      tick_r      <= '0;
      run_valid_r <= 1'b0;
      run_idx_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r         <= in_op;
            ticks_r      <= in_sleep_ticks;
            res_status_r <= STAT_OK;
            res_chosen_r <= '0;
            res_time_r   <= '0;
            unique case (in_op)
              OP_TICK: begin
                tick_r   <= tick_r + TICK_W'(1);
                rd_ptr_r <= '0;
                pend_r   <= 1'b0;
                state_r  <= S_SCAN;
              end
              OP_ADD: begin
                if (tiu_r == TW'(TASK_SLOTS)) begin
                  res_status_r <= STAT_FULL;
                end else begin
                  tiu_r        <= tiu_r + TW'(1);
                  res_chosen_r <= IDX_W'(tiu_r);
                end
                state_r <= S_RESP;
              end
              OP_DISPATCH: begin
                fin_en_r     <= run_valid_r;
                fin_idx_r    <= run_idx_r;
                run_valid_r  <= 1'b0;
                best_found_r <= 1'b0;
                best_prio_r  <= '0;
                rd_ptr_r     <= '0;
                pend_r       <= 1'b0;
                state_r      <= S_SCAN;
              end
              OP_SLEEP, OP_DONE: begin
                if (run_valid_r) begin
                  rmw_addr_r <= run_idx_r;
                  state_r    <= S_RMW_WR;
                  if (in_op == OP_DONE) begin
                    run_valid_r <= 1'b0;
                  end
                end else begin
                  res_status_r <= STAT_IGNORED;
                  state_r      <= S_RESP;
                end
              end
              OP_SUSPEND, OP_RESUME: begin
                if (idx_ok) begin
                  rmw_addr_r <= SW'(in_task_index);
                  state_r    <= S_RMW_WR;
                end else begin
                  res_status_r <= STAT_IGNORED;
                  state_r      <= S_RESP;
                end
              end
              default: begin
                res_status_r <= STAT_IGNORED;
                state_r      <= S_RESP;
              end
            endcase
          end
        end
        S_SCAN: begin
          rd_ptr_r    <= rd_ptr_r + TW'(scan_issue);
          pend_r      <= scan_issue;
          pend_addr_r <= rd_ptr_r[SW-1:0];
          if (pend_r && op_r == OP_DISPATCH && scan_better) begin
            best_found_r <= 1'b1;
            best_prio_r  <= scan_rec.prio;
            best_idx_r   <= pend_addr_r;
            best_rec_r   <= scan_rec;
          end
          if (!scan_issue && !pend_r) begin
            if (op_r == OP_DISPATCH && best_found_r) begin
              state_r <= S_PICK;
            end else begin
              if (op_r == OP_DISPATCH) begin
                res_status_r <= STAT_NONE;
              end
              state_r <= S_RESP;
            end
          end
        end
        S_RMW_WR: begin
          state_r <= S_RESP;
        end
        S_PICK: begin
          run_valid_r  <= 1'b1;
          run_idx_r    <= best_idx_r;
          res_chosen_r <= IDX_W'(best_idx_r);
          res_time_r   <= tick_r;
          state_r      <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_chosen_r <= res_chosen_r;
            out_time_r   <= res_time_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_tiu_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(tiu_r) <= TASK_SLOTS)
    else $error("task count exceeds the table size");

  a_running_added: assert property (@(posedge clk) disable iff (!rst_n)
    run_valid_r |-> (32'(run_idx_r) < 32'(tiu_r)))
    else $error("running task lies outside the added slots");

  a_scan_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("sweep writes the slot it is reading");

  a_pick_sets_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK) |=> (run_valid_r && state_r == S_RESP))
    else $error("dispatch did not record the running task");

endmodule
